### rtl/ticketed_reader_writer_lock_assert.svh
// Assertion macros for the ticketed reader/writer lock.
`ifndef TICKETED_READER_WRITER_LOCK_ASSERT_SVH
`define TICKETED_READER_WRITER_LOCK_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define TRWL_ASSERT_IMP(lbl, ck, rn, a, c) \
  lbl: assert property (@(posedge ck) disable iff (!(rn)) (a) |-> (c)) \
    else $error("lock invariant violated");
`define TRWL_ASSERT_NXT(lbl, ck, rn, a, c) \
  lbl: assert property (@(posedge ck) disable iff (!(rn)) (a) |=> (c)) \
    else $error("lock sequencing violated");
`else
`define TRWL_ASSERT_IMP(lbl, ck, rn, a, c)
`define TRWL_ASSERT_NXT(lbl, ck, rn, a, c)
`endif
`endif

### rtl/trwl_pkg.sv
// Shared constants, codes and types of the ticketed reader/writer lock.
package trwl_pkg;
  localparam int MAX_READERS = 8;
  localparam int MAX_WAITERS = 16;
  localparam int ID_BITS     = 16;
  localparam int TICKET_W    = 16;
  localparam int RD_IDX_W    = $clog2(MAX_READERS);
  localparam int AB_IDX_W    = $clog2(MAX_WAITERS);
  localparam int RD_CNT_W    = $clog2(MAX_READERS + 1);

  localparam logic [2:0] CMD_ACQUIRE = 3'd0;
  localparam logic [2:0] CMD_TRY     = 3'd1;
  localparam logic [2:0] CMD_POLL    = 3'd2;
  localparam logic [2:0] CMD_CANCEL  = 3'd3;
  localparam logic [2:0] CMD_RELEASE = 3'd4;

  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_WAIT     = 3'd1;
  localparam logic [2:0] ST_DEADLOCK = 3'd2;
  localparam logic [2:0] ST_BUSY     = 3'd3;
  localparam logic [2:0] ST_INVALID  = 3'd4;
  localparam logic [2:0] ST_INTR     = 3'd5;

  typedef enum logic [6:0] {
    S_IDLE = 7'b0000001,
    S_ARD  = 7'b0000010,
    S_ACMP = 7'b0000100,
    S_RRD  = 7'b0001000,
    S_RCMP = 7'b0010000,
    S_EXEC = 7'b0100000,
    S_OUT  = 7'b1000000
  } state_t;
endpackage

### rtl/trwl_ram.sv
// Simple dual-port RAM, one write and one registered read port.
module trwl_ram #(
  parameter int DEPTH = 8,
  parameter int WIDTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

### rtl/ticketed_reader_writer_lock.sv
// Ticketed reader/writer lock: top level with sequencer and state tables.
//
// A fair reader/writer lock that serves tickets strictly in order. Each input
// beat carries a command (acquire, try acquire, poll, cancel, release), a
// nonzero requester id, the write flag, a ticket and the file's locked flag;
// each input beat yields exactly one output beat with a status, the ticket
// issued by an acquire (else zero) and the new locked flag. Reader ids and
// abandoned tickets live in two small RAMs with registered read ports; their
// valid bits, the ticket counters and the writer id are flops. An item that
// needs no table search steps from idle through execute to output. A poll or
// cancel searches the abandoned table entry by entry, a read state and then a
// compare state per entry, a read release searches the reader table the same
// way, and every time the serving ticket advances the abandoned table is
// rescanned once per skipped ticket. Items are handled one at a time; the next
// input beat is taken as soon as the result sits in the output register, even
// while that result is still stalled. RAM writes happen only in the execute
// step, so no read of the same entry ever overlaps them.
module ticketed_reader_writer_lock (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [2:0]  in_command,
  input  logic [15:0] in_requester_id,
  input  logic        in_wants_write,
  input  logic [15:0] in_ticket,
  input  logic        in_file_locked,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  out_status,
  output logic [15:0] out_issued_ticket,
  output logic        out_file_locked_next
);
  `include "ticketed_reader_writer_lock_assert.svh"

  localparam int TW = trwl_pkg::TICKET_W;
  localparam int IW = trwl_pkg::ID_BITS;
  localparam int NR = trwl_pkg::MAX_READERS;
  localparam int NA = trwl_pkg::MAX_WAITERS;
  localparam int RX = trwl_pkg::RD_IDX_W;
  localparam int AX = trwl_pkg::AB_IDX_W;
  localparam int RC = trwl_pkg::RD_CNT_W;

  trwl_pkg::state_t state_r, state_nxt;

  // Latched request beat.
  logic [2:0]    cmd_r;
  logic [IW-1:0] id_r;
  logic          wr_r, fl_r;
  logic [TW-1:0] tk_r;

  // Lock state.
  logic [TW-1:0] next_r, next_nxt, serv_r, serv_nxt;
  logic [IW-1:0] writer_r, writer_nxt;
  logic [NR-1:0] rvalid_r, rvalid_nxt;
  logic [RC-1:0] rtotal_r, rtotal_nxt;
  logic [NA-1:0] avalid_r, avalid_nxt;

  // Search bookkeeping.
  logic [AX-1:0] adx_r, adx_nxt;
  logic [RX-1:0] rdx_r, rdx_nxt;
  logic          adv_r, adv_nxt;
  logic          ahit_r, ahit_nxt, rhit_r, rhit_nxt;
  logic [RX-1:0] rhit_idx_r, rhit_idx_nxt;

  // Result of the item, then the output register.
  logic [2:0]    st_r, st_nxt;
  logic [TW-1:0] iss_r, iss_nxt;
  logic          fln_r, fln_nxt;
  logic          ov_r;
  logic [2:0]    os_r;
  logic [TW-1:0] oi_r;
  logic          of_r;

  // RAM ports.
  logic          rd_we, ab_we;
  logic [RX-1:0] rd_waddr;
  logic [AX-1:0] ab_waddr;
  logic [IW-1:0] rd_rdata;
  logic [TW-1:0] ab_rdata;

  trwl_ram #(.DEPTH(NR), .WIDTH(IW)) u_readers (
    .clk(clk), .we(rd_we), .waddr(rd_waddr), .wdata(id_r),
    .raddr(rdx_r), .rdata(rd_rdata)
  );

  trwl_ram #(.DEPTH(NA), .WIDTH(TW)) u_abandoned (
    .clk(clk), .we(ab_we), .waddr(ab_waddr), .wdata(tk_r),
    .raddr(adx_r), .rdata(ab_rdata)
  );

  // Lowest free reader slot and lowest free abandoned entry.
  logic [RX-1:0] rfree_idx;
  logic [AX-1:0] afree_idx;
  logic          rfull, afull;

  always_comb begin
    rfree_idx = '0;
    for (int i = NR - 1; i >= 0; i--) begin
      if (!rvalid_r[i]) rfree_idx = RX'(i);
    end
    afree_idx = '0;
    for (int i = NA - 1; i >= 0; i--) begin
      if (!avalid_r[i]) afree_idx = AX'(i);
    end
    rfull = &rvalid_r;
    afull = &avalid_r;
  end

  logic          can_grant, waiting, id_bad, grant, advance;
  logic [TW-1:0] dist_t, dist_n, akey;

  assign akey      = adv_r ? serv_r : tk_r;
  assign id_bad    = (id_r == '0) || (cmd_r > trwl_pkg::CMD_RELEASE);
  assign can_grant = (writer_r == '0) && (wr_r ? (rtotal_r == '0) : !rfull);
  assign dist_t    = tk_r - serv_r;
  assign dist_n    = next_r - serv_r;
  assign waiting   = (dist_t < dist_n) && !ahit_r;

  always_comb begin
    state_nxt    = state_r;
    next_nxt     = next_r;
    serv_nxt     = serv_r;
    writer_nxt   = writer_r;
    rvalid_nxt   = rvalid_r;
    rtotal_nxt   = rtotal_r;
    avalid_nxt   = avalid_r;
    adx_nxt      = adx_r;
    rdx_nxt      = rdx_r;
    adv_nxt      = adv_r;
    ahit_nxt     = ahit_r;
    rhit_nxt     = rhit_r;
    rhit_idx_nxt = rhit_idx_r;
    st_nxt       = st_r;
    iss_nxt      = iss_r;
    fln_nxt      = fln_r;
    rd_we        = 1'b0;
    ab_we        = 1'b0;
    rd_waddr     = rfree_idx;
    ab_waddr     = afree_idx;
    grant        = 1'b0;
    advance      = 1'b0;

    case (state_r)
      trwl_pkg::S_IDLE: begin
        if (in_valid) begin
          adx_nxt  = '0;
          rdx_nxt  = '0;
          adv_nxt  = 1'b0;
          ahit_nxt = 1'b0;
          rhit_nxt = 1'b0;
          if (in_requester_id != '0 && (in_command == trwl_pkg::CMD_POLL ||
              in_command == trwl_pkg::CMD_CANCEL)) begin
            state_nxt = trwl_pkg::S_ARD;
          end else if (in_requester_id != '0 && in_command == trwl_pkg::CMD_RELEASE &&
                       !in_wants_write && in_file_locked && rtotal_r != '0) begin
            state_nxt = trwl_pkg::S_RRD;
          end else begin
            state_nxt = trwl_pkg::S_EXEC;
          end
        end
      end
      trwl_pkg::S_ARD: state_nxt = trwl_pkg::S_ACMP;
      trwl_pkg::S_ACMP: begin
        if (avalid_r[adx_r] && ab_rdata == akey) begin
          if (adv_r) begin
            // Skip and drop the abandoned ticket, then rescan from the top.
            avalid_nxt[adx_r] = 1'b0;
            serv_nxt          = serv_r + 1'b1;
            adx_nxt           = '0;
            state_nxt         = trwl_pkg::S_ARD;
          end else begin
            ahit_nxt  = 1'b1;
            state_nxt = trwl_pkg::S_EXEC;
          end
        end else if (adx_r == AX'(NA - 1)) begin
          state_nxt = adv_r ? trwl_pkg::S_OUT : trwl_pkg::S_EXEC;
        end else begin
          adx_nxt   = adx_r + 1'b1;
          state_nxt = trwl_pkg::S_ARD;
        end
      end
      trwl_pkg::S_RRD: state_nxt = trwl_pkg::S_RCMP;
      trwl_pkg::S_RCMP: begin
        if (rvalid_r[rdx_r] && rd_rdata == id_r) begin
          rhit_nxt     = 1'b1;
          rhit_idx_nxt = rdx_r;
          state_nxt    = trwl_pkg::S_EXEC;
        end else if (rdx_r == RX'(NR - 1)) begin
          state_nxt = trwl_pkg::S_EXEC;
        end else begin
          rdx_nxt   = rdx_r + 1'b1;
          state_nxt = trwl_pkg::S_RRD;
        end
      end
      trwl_pkg::S_EXEC: begin
        st_nxt  = trwl_pkg::ST_INVALID;
        iss_nxt = '0;
        fln_nxt = fl_r;
        if (id_bad) begin
          st_nxt = trwl_pkg::ST_INVALID;
        end else begin
          case (cmd_r)
            trwl_pkg::CMD_ACQUIRE: begin
              if (writer_r == id_r) begin
                st_nxt = trwl_pkg::ST_DEADLOCK;
              end else if (!wr_r && rfull) begin
                st_nxt = trwl_pkg::ST_BUSY;
              end else begin
                iss_nxt  = next_r;
                next_nxt = next_r + 1'b1;
                if (next_r == serv_r && can_grant) begin
                  grant   = 1'b1;
                  advance = 1'b1;
                  st_nxt  = trwl_pkg::ST_OK;
                  fln_nxt = 1'b1;
                end else begin
                  st_nxt = trwl_pkg::ST_WAIT;
                end
              end
            end
            trwl_pkg::CMD_TRY: begin
              if (next_r != serv_r || writer_r == id_r || !can_grant) begin
                st_nxt = trwl_pkg::ST_BUSY;
              end else begin
                grant   = 1'b1;
                st_nxt  = trwl_pkg::ST_OK;
                fln_nxt = 1'b1;
              end
            end
            trwl_pkg::CMD_POLL: begin
              if (!waiting) begin
                st_nxt = trwl_pkg::ST_INVALID;
              end else if (tk_r == serv_r && can_grant) begin
                grant   = 1'b1;
                advance = 1'b1;
                st_nxt  = trwl_pkg::ST_OK;
                fln_nxt = 1'b1;
              end else begin
                st_nxt = trwl_pkg::ST_WAIT;
              end
            end
            trwl_pkg::CMD_CANCEL: begin
              if (!waiting) begin
                st_nxt = trwl_pkg::ST_INVALID;
              end else if (tk_r == serv_r) begin
                advance = 1'b1;
                st_nxt  = trwl_pkg::ST_INTR;
              end else if (!afull) begin
                ab_we                 = 1'b1;
                avalid_nxt[afree_idx] = 1'b1;
                st_nxt                = trwl_pkg::ST_INTR;
              end else begin
                st_nxt = trwl_pkg::ST_BUSY;
              end
            end
            trwl_pkg::CMD_RELEASE: begin
              if (!fl_r) begin
                st_nxt = trwl_pkg::ST_INVALID;
              end else if (wr_r) begin
                if (writer_r == id_r) begin
                  writer_nxt = '0;
                  if (rtotal_r == '0) fln_nxt = 1'b0;
                  st_nxt = trwl_pkg::ST_OK;
                end
              end else if (rhit_r) begin
                rvalid_nxt[rhit_idx_r] = 1'b0;
                rtotal_nxt             = rtotal_r - 1'b1;
                if (rtotal_r == RC'(1) && writer_r == '0) fln_nxt = 1'b0;
                st_nxt = trwl_pkg::ST_OK;
              end
            end
            default: st_nxt = trwl_pkg::ST_INVALID;
          endcase
        end
        if (grant) begin
          if (wr_r) begin
            writer_nxt = id_r;
          end else begin
            rd_we                 = 1'b1;
            rvalid_nxt[rfree_idx] = 1'b1;
            rtotal_nxt            = rtotal_r + 1'b1;
          end
        end
        if (advance) begin
          // Step past the served ticket, then skip any abandoned ones.
          serv_nxt  = serv_r + 1'b1;
          adv_nxt   = 1'b1;
          adx_nxt   = '0;
          state_nxt = trwl_pkg::S_ARD;
        end else begin
          state_nxt = trwl_pkg::S_OUT;
        end
      end
      trwl_pkg::S_OUT: begin
        if (!ov_r || !out_stall) state_nxt = trwl_pkg::S_IDLE;
      end
      default: state_nxt = trwl_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= trwl_pkg::S_IDLE;
      next_r   <= '0;
      serv_r   <= '0;
      writer_r <= '0;
      rvalid_r <= '0;
      rtotal_r <= '0;
      avalid_r <= '0;
      adv_r    <= 1'b0;
      ov_r     <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      next_r   <= next_nxt;
      serv_r   <= serv_nxt;
      writer_r <= writer_nxt;
      rvalid_r <= rvalid_nxt;
      rtotal_r <= rtotal_nxt;
      avalid_r <= avalid_nxt;
      adv_r    <= adv_nxt;
      if (state_r == trwl_pkg::S_OUT && (!ov_r || !out_stall)) begin
        ov_r <= 1'b1;
      end else if (!out_stall) begin
        ov_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == trwl_pkg::S_IDLE && in_valid) begin
      cmd_r <= in_command;
      id_r  <= in_requester_id;
      wr_r  <= in_wants_write;
      tk_r  <= in_ticket;
      fl_r  <= in_file_locked;
    end
    adx_r      <= adx_nxt;
    rdx_r      <= rdx_nxt;
    ahit_r     <= ahit_nxt;
    rhit_r     <= rhit_nxt;
    rhit_idx_r <= rhit_idx_nxt;
    st_r       <= st_nxt;
    iss_r      <= iss_nxt;
    fln_r      <= fln_nxt;
    if (state_r == trwl_pkg::S_OUT && (!ov_r || !out_stall)) begin
      os_r <= st_r;
      oi_r <= iss_r;
      of_r <= fln_r;
    end
  end

  assign in_stall             = (state_r != trwl_pkg::S_IDLE);
  assign out_valid            = ov_r;
  assign out_status           = os_r;
  assign out_issued_ticket    = oi_r;
  assign out_file_locked_next = of_r;

  // Reader count tracks the slot valid bits.
  `TRWL_ASSERT_IMP(a_rtotal, clk, rst_n, 1'b1, rtotal_r == RC'($countones(rvalid_r)))
  // A writer and readers never hold the lock together.
  `TRWL_ASSERT_IMP(a_excl, clk, rst_n, writer_r != '0, rtotal_r == '0)
  // Only a waiting or granted acquire hands out a nonzero ticket.
  `TRWL_ASSERT_IMP(a_issue, clk, rst_n, ov_r && oi_r != '0,
                   os_r == trwl_pkg::ST_OK || os_r == trwl_pkg::ST_WAIT)
  // Unless the output is stalled, a finished item lands in the output register on the next edge.
  `TRWL_ASSERT_NXT(a_load, clk, rst_n, state_r == trwl_pkg::S_OUT && !out_stall, ov_r)
endmodule
